>>> hw/rtl/sorted_set_lower_bound_rank_top_assert.svh
// Assertion helpers, clocked on clk, disabled while rst_n is low
`ifndef SORTED_SET_LOWER_BOUND_RANK_TOP_ASSERT_SVH
`define SORTED_SET_LOWER_BOUND_RANK_TOP_ASSERT_SVH

// same-cycle implication
`define SSLB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSLB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sslb_pkg.sv
`default_nettype none
package sslb_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 11;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef struct packed {
    logic vld;
    op_t  op;
  } tok_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/sslb_cell.sv
`default_nettype none
module sslb_cell #(
  parameter int CW = 11
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire sslb_pkg::tok_ctl_t             ctl_i,
  input  wire logic signed [sslb_pkg::VAL_W-1:0] val_i,
  input  wire logic [CW-1:0]                  cnt_i,
  output sslb_pkg::tok_ctl_t                  ctl_o,
  output logic signed [sslb_pkg::VAL_W-1:0]   val_o,
  output logic [CW-1:0]                       cnt_o
);
  import sslb_pkg::*;

  logic                    full_r, full_nxt;
  logic signed [VAL_W-1:0] data_r, data_nxt;
  tok_ctl_t                ctl_r, ctl_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;

  always_comb begin
    full_nxt = full_r;
    data_nxt = data_r;
    ctl_nxt  = ctl_i;
    val_nxt  = val_i;
    cnt_nxt  = cnt_i;
    if (ctl_i.vld) begin
      case (ctl_i.op)
        OP_INSERT: begin
          if (!full_r) begin
            full_nxt    = 1'b1;
            data_nxt    = val_i;
            ctl_nxt.vld = 1'b0;
          end else if (val_i < data_r) begin
            data_nxt = val_i;
            val_nxt  = data_r;
          end
        end
        OP_QUERY: begin
          if (full_r && (data_r < val_i)) begin
            cnt_nxt = cnt_i + CW'(1);
          end
        end
        default: begin
          ctl_nxt.vld = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      ctl_r  <= '0;
    end else begin
      full_r <= full_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    val_r  <= val_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign ctl_o = ctl_r;
  assign val_o = val_r;
  assign cnt_o = cnt_r;

endmodule
`default_nettype wire

>>> hw/rtl/sslb_chain.sv
`default_nettype none
module sslb_chain #(
  parameter int CAPACITY = 1024,
  parameter int CW       = 11
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire sslb_pkg::tok_ctl_t                ctl_i,
  input  wire logic signed [sslb_pkg::VAL_W-1:0] val_i,
  output sslb_pkg::tok_ctl_t                     ctl_o,
  output logic [CW-1:0]                          cnt_o
);
  import sslb_pkg::*;

  tok_ctl_t                ctl_w [CAPACITY+1];
  logic signed [VAL_W-1:0] val_w [CAPACITY+1];
  logic [CW-1:0]           cnt_w [CAPACITY+1];

  assign ctl_w[0] = ctl_i;
  assign val_w[0] = val_i;
  assign cnt_w[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sslb_cell #(
      .CW (CW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_w[i]),
      .val_i (val_w[i]),
      .cnt_i (cnt_w[i]),
      .ctl_o (ctl_w[i+1]),
      .val_o (val_w[i+1]),
      .cnt_o (cnt_w[i+1])
    );
  end

  assign ctl_o = ctl_w[CAPACITY];
  assign cnt_o = cnt_w[CAPACITY];

endmodule
`default_nettype wire

>>> hw/rtl/sorted_set_lower_bound_rank_top.sv
`default_nettype none
// channel   ports                          width     direction
// input     start/busy, in_op, in_value    1 + 32    in
// result    out_strobe, out_position       11        out
//
// One word is taken in every cycle; busy stays low.
// A query leaves out_position once it has walked the whole row of cells,
// one cell per cycle, passing through the register of every cell.
// An insert travels the same row and settles in the first free cell.
// Reset empties every cell at once; no clearing pass.
// The receiver cannot stall: out_strobe lasts one cycle per result.
`include "sorted_set_lower_bound_rank_top_assert.svh"
module sorted_set_lower_bound_rank_top #(
  parameter int CAPACITY = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_op,
  input  wire logic signed [sslb_pkg::VAL_W-1:0] in_value,
  output logic                                   out_strobe,
  output logic [sslb_pkg::POS_W-1:0]             out_position
);
  import sslb_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic          accept;
  logic          store_full;
  logic          ins_drop;
  logic [CW-1:0] cnt_r, cnt_nxt;
  tok_ctl_t      inj_ctl;
  tok_ctl_t      tail_ctl;
  logic [CW-1:0] tail_cnt;
  logic [CW:0]   pos_wide;

  assign busy       = 1'b0;
  assign accept     = start && !busy;
  assign store_full = (cnt_r == CW'(CAPACITY));
  assign ins_drop   = accept && (op_t'(in_op) == OP_INSERT) && store_full;

  always_comb begin
    inj_ctl.op  = op_t'(in_op);
    inj_ctl.vld = accept && ((op_t'(in_op) == OP_QUERY) || !store_full);
    cnt_nxt     = cnt_r;
    if (inj_ctl.vld && (inj_ctl.op == OP_INSERT)) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  sslb_chain #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (inj_ctl),
    .val_i (in_value),
    .ctl_o (tail_ctl),
    .cnt_o (tail_cnt)
  );

  assign pos_wide     = {1'b0, tail_cnt} + {{CW{1'b0}}, 1'b1};
  assign out_strobe   = tail_ctl.vld && (tail_ctl.op == OP_QUERY);
  assign out_position = POS_W'(pos_wide);

  `SSLB_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(CAPACITY), "stored count above capacity")
  `SSLB_ASSERT_NXT(a_full_drop, ins_drop, $stable(cnt_r), "full-store insert counted")
  `SSLB_ASSERT_IMP(a_rank_bound, out_strobe, tail_cnt <= cnt_r, "rank exceeds stored count")
  `SSLB_ASSERT_IMP(a_no_spill, tail_ctl.vld, tail_ctl.op == OP_QUERY, "insert left the row")

endmodule
`default_nettype wire

>>> test/sslb_checker.sv
`timescale 1ns / 1ps
module sslb_checker #(
  parameter int CAPACITY = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic                              busy,
  input  wire logic                              in_op,
  input  wire logic signed [sslb_pkg::VAL_W-1:0] in_value,
  input  wire logic                              out_strobe,
  input  wire logic [sslb_pkg::POS_W-1:0]        out_position,
  output int                                     mismatches,
  output int                                     positions_due
);
  import sslb_pkg::*;

  logic signed [VAL_W-1:0] held_keys[$];
  logic [POS_W-1:0]        due_positions[$];
  int                      bad_count = 0;

  function automatic int count_below(input logic signed [VAL_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = held_keys.size();
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (held_keys[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  always @(posedge clk) begin : track
    logic [POS_W-1:0] want;
    if (!rst_n) begin
      held_keys.delete();
      due_positions.delete();
      bad_count = 0;
    end else begin
      if (out_strobe) begin
        if (due_positions.size() == 0) begin
          bad_count++;
          $display("%0t: unexpected position word, expected none, actual %0d",
                   $time, out_position);
        end else begin
          want = due_positions.pop_front();
          if (out_position !== want) begin
            bad_count++;
            $display("%0t: position mismatch, expected %0d, actual %0d",
                     $time, want, out_position);
          end
        end
      end
      if (start && !busy) begin
        if (op_t'(in_op) == OP_QUERY) begin
          due_positions.push_back(POS_W'(count_below(in_value) + 1));
        end else if (held_keys.size() < CAPACITY) begin
          held_keys.insert(count_below(in_value), in_value);
        end
      end
    end
    mismatches <= bad_count;
    positions_due <= due_positions.size();
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
  import sslb_pkg::*;

  localparam int CAPACITY    = 1024;
  localparam int STALL_LIMIT = 4 * CAPACITY + 256;
  localparam logic signed [VAL_W-1:0] KEY_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] KEY_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    in_op = 1'b0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    busy;
  logic                    out_strobe;
  logic [POS_W-1:0]        out_position;
  int                      mismatches;
  int                      positions_due;

  logic signed [VAL_W-1:0] loaded[$];
  bit                      no_gaps = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_set_lower_bound_rank_top #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_value(in_value),
    .out_strobe(out_strobe),
    .out_position(out_position)
  );

  sslb_checker #(
    .CAPACITY(CAPACITY)
  ) u_check (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_value(in_value),
    .out_strobe(out_strobe),
    .out_position(out_position),
    .mismatches(mismatches),
    .positions_due(positions_due)
  );

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_strobe) idle = 0;
      else idle++;
    end
    $display("** sorted_set_lower_bound_rank_top: FAILED **");
    $finish;
  end

  function automatic logic signed [VAL_W-1:0] pick_key();
    int off;
    off = $urandom_range(0, 2);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return KEY_MIN + $urandom_range(0, 3);
      2: return KEY_MAX - $urandom_range(0, 3);
      3: return $urandom_range(0, 64) - 32;
      default: begin
        if (loaded.size() == 0) return $urandom;
        return loaded[$urandom_range(0, loaded.size() - 1)] + off - 1;
      end
    endcase
  endfunction

  // keep the top key free so that a full store can still answer count + 1
  function automatic logic signed [VAL_W-1:0] pick_load();
    logic signed [VAL_W-1:0] v;
    v = pick_key();
    return (v == KEY_MAX) ? KEY_MAX - 1 : v;
  endfunction

  task automatic send_word(input op_t op, input logic signed [VAL_W-1:0] v);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_value <= v;
    do @(posedge clk); while (busy);
    if (op == OP_INSERT && loaded.size() < CAPACITY) loaded.push_back(v);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    do @(posedge clk); while (positions_due != 0);
  endtask

  task automatic send_random(input int n);
    repeat (n) begin
      if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
      if ($urandom_range(0, 99) == 0) drain();
      if ($urandom_range(0, 1) == 0) send_word(OP_INSERT, pick_load());
      else send_word(OP_QUERY, pick_key());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_word(OP_QUERY, KEY_MIN);
    send_word(OP_QUERY, KEY_MAX);
    send_word(OP_INSERT, 0);
    send_word(OP_QUERY, KEY_MAX);
    send_word(OP_QUERY, 0);
    send_word(OP_INSERT, KEY_MIN);
    send_word(OP_INSERT, KEY_MAX - 1);
    send_word(OP_INSERT, 0);
    send_word(OP_INSERT, -1);
    send_word(OP_INSERT, 1);
    send_word(OP_QUERY, KEY_MIN);
    send_word(OP_QUERY, KEY_MIN + 1);
    send_word(OP_QUERY, -1);
    send_word(OP_QUERY, 0);
    send_word(OP_QUERY, 1);
    send_word(OP_QUERY, 2);
    send_word(OP_QUERY, KEY_MAX - 1);
    send_word(OP_QUERY, KEY_MAX);
    drain();

    send_random(400);
    drain();

    // fill the store, then push a few words past capacity
    no_gaps = 1'b0;
    while (loaded.size() < CAPACITY) begin
      if ($urandom_range(0, 7) == 0) send_word(OP_QUERY, pick_key());
      else send_word(OP_INSERT, pick_load());
    end
    repeat (4) send_word(OP_INSERT, pick_load());
    send_word(OP_INSERT, KEY_MAX);
    send_word(OP_QUERY, KEY_MAX);
    send_word(OP_QUERY, KEY_MIN);
    send_word(OP_QUERY, KEY_MAX - 1);
    repeat (30) send_word(OP_QUERY, pick_key());

    drain();
    repeat (CAPACITY + 16) @(posedge clk);
    if (mismatches == 0 && positions_due == 0) begin
      $display("** sorted_set_lower_bound_rank_top: PASSED **");
    end else begin
      $display("** sorted_set_lower_bound_rank_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/sslb_pkg.sv
hw/rtl/sslb_cell.sv
hw/rtl/sslb_chain.sv
hw/rtl/sorted_set_lower_bound_rank_top.sv
test/sslb_checker.sv
test/tb.sv
